// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master register access: shared types and constants
// Command and response item layouts, sequencer state encoding, mode, kind and
// status codes used by the sequencer, the output stage and the top level.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Command modes.
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_PROBE = 3'd1;
  localparam logic [2:0] MODE_READ  = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_DATA  = 3'd4;

  // Transaction kinds share the low two bits of the starting mode.
  localparam logic [1:0] KIND_PROBE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Completion status.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NACK = 2'd1;
  localparam logic [1:0] STATUS_BUSY = 2'd2;

  // Read/write flag ORed into the device address byte.
  localparam logic [7:0] RW_READ = 8'h01;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'd0,
    ST_START1    = 5'd1,
    ST_ADDRW     = 5'd2,
    ST_ACK_ADDRW = 5'd3,
    ST_REG       = 5'd4,
    ST_ACK_REG   = 5'd5,
    ST_START2    = 5'd6,
    ST_ADDRR     = 5'd7,
    ST_ACK_ADDRR = 5'd8,
    ST_RDBYTE    = 5'd9,
    ST_RDACK     = 5'd10,
    ST_WAIT_DATA = 5'd11,
    ST_WRBYTE    = 5'd12,
    ST_ACK_WR    = 5'd13,
    ST_STOP_OK   = 5'd14,
    ST_STOP_NACK = 5'd15
  } seq_state_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] target_address;
    logic [7:0] register_address;
    logic [7:0] transfer_length;
    logic [7:0] write_byte;
    logic       sda_in;
    logic       scl_in;
  } cmd_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       data_request;
    logic       done_res;
    logic [1:0] status;
    logic       busy_res;
  } rsp_item_t;

endpackage

// ===== rtl/i2cm_cmd_if.sv =====
// ----------------------------------------------------------------------------
// I2C master register access: command channel
// Valid/ready channel carrying one command item per transaction.
// ----------------------------------------------------------------------------
interface i2cm_cmd_if
  import i2cm_pkg::*;
();
  logic      valid;
  logic      ready;
  cmd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/i2cm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// I2C master register access: response channel
// Valid/ready channel carrying one response item per transaction.
// ----------------------------------------------------------------------------
interface i2cm_rsp_if
  import i2cm_pkg::*;
();
  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// I2C master register access: bus sequencer
// Holds the sequencer state and advances it by at most one phase per accepted
// command, producing the response item of that command.
// ----------------------------------------------------------------------------
module i2cm_seq
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  cmd_item_t cmd,
  output rsp_item_t rsp
);

  seq_state_t state, state_next;
  logic [1:0] phase, phase_next;
  logic [2:0] bit_idx, bit_idx_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [1:0] kind, kind_next;
  logic [7:0] dev_addr, dev_addr_next;
  logic [7:0] reg_addr, reg_addr_next;
  logic       scl, scl_next;
  logic       sda, sda_next;

  logic       tick;
  logic       last_bit;
  logic       bus_free;
  logic [7:0] bytes_dec;

  assign tick      = (cmd.mode == MODE_TICK);
  assign last_bit  = (bit_idx == 3'd7);
  assign bus_free  = cmd.sda_in & cmd.scl_in;
  assign bytes_dec = (bytes_left != 8'd0) ? bytes_left - 8'd1 : bytes_left;

  // Next-state logic.
  always_comb begin
    state_next      = state;
    phase_next      = phase;
    bit_idx_next    = bit_idx;
    bytes_left_next = bytes_left;
    shift_byte_next = shift_byte;
    kind_next       = kind;
    dev_addr_next   = dev_addr;
    reg_addr_next   = reg_addr;
    scl_next        = scl;
    sda_next        = sda;

    if (state == ST_IDLE) begin
      if (cmd.mode inside {MODE_PROBE, MODE_READ, MODE_WRITE}) begin
        if (!(cmd.mode == MODE_PROBE && !bus_free)) begin
          dev_addr_next   = cmd.target_address;
          reg_addr_next   = cmd.register_address;
          bytes_left_next = cmd.transfer_length;
          kind_next       = cmd.mode[1:0];
          state_next      = ST_START1;
          shift_byte_next = 8'd0;
          bit_idx_next    = 3'd0;
          phase_next      = 2'd0;
        end
      end
    end else if (state == ST_WAIT_DATA) begin
      if (cmd.mode == MODE_DATA) begin
        state_next      = ST_WRBYTE;
        shift_byte_next = cmd.write_byte;
        bit_idx_next    = 3'd0;
        phase_next      = 2'd0;
      end
    end else if (tick) begin
      case (state)
        ST_START1, ST_START2: begin
          if (phase == 2'd0) begin
            sda_next   = 1'b1;
            scl_next   = 1'b1;
            phase_next = 2'd1;
          end else if (phase == 2'd1) begin
            sda_next   = 1'b0;
            phase_next = 2'd2;
          end else begin
            scl_next     = 1'b0;
            bit_idx_next = 3'd0;
            phase_next   = 2'd0;
            if (state == ST_START1) begin
              state_next      = ST_ADDRW;
              shift_byte_next = dev_addr;
            end else begin
              state_next      = ST_ADDRR;
              shift_byte_next = dev_addr | RW_READ;
            end
          end
        end
        ST_ADDRW, ST_REG, ST_ADDRR, ST_WRBYTE: begin
          if (phase == 2'd0) begin
            // Bits go out MSB first: bit_idx counts from the top.
            sda_next   = shift_byte[~bit_idx];
            phase_next = 2'd1;
          end else if (phase == 2'd1) begin
            scl_next   = 1'b1;
            phase_next = 2'd2;
          end else begin
            scl_next   = 1'b0;
            phase_next = 2'd0;
            if (last_bit) begin
              bit_idx_next    = 3'd0;
              shift_byte_next = 8'd0;
              case (state)
                ST_ADDRW: state_next = ST_ACK_ADDRW;
                ST_REG:   state_next = ST_ACK_REG;
                ST_ADDRR: state_next = ST_ACK_ADDRR;
                default:  state_next = ST_ACK_WR;
              endcase
            end else begin
              bit_idx_next = bit_idx + 3'd1;
            end
          end
        end
        ST_ACK_ADDRW, ST_ACK_REG, ST_ACK_ADDRR, ST_ACK_WR: begin
          if (phase == 2'd0) begin
            sda_next   = 1'b1;
            phase_next = 2'd1;
          end else if (phase == 2'd1) begin
            scl_next   = 1'b1;
            phase_next = 2'd2;
          end else begin
            scl_next        = 1'b0;
            sda_next        = 1'b1;
            phase_next      = 2'd0;
            bit_idx_next    = 3'd0;
            shift_byte_next = 8'd0;
            if (cmd.sda_in) begin
              state_next = ST_STOP_NACK;
            end else begin
              case (state)
                ST_ACK_ADDRW: begin
                  state_next      = (kind == KIND_PROBE) ? ST_STOP_OK : ST_REG;
                  shift_byte_next = reg_addr;
                end
                ST_ACK_REG: begin
                  if (kind == KIND_READ) begin
                    state_next = ST_START2;
                  end else begin
                    state_next = (bytes_left == 8'd0) ? ST_STOP_OK : ST_WAIT_DATA;
                  end
                end
                ST_ACK_ADDRR: begin
                  state_next = (bytes_left == 8'd0) ? ST_STOP_OK : ST_RDBYTE;
                end
                default: begin
                  bytes_left_next = bytes_dec;
                  state_next      = (bytes_dec == 8'd0) ? ST_STOP_OK : ST_WAIT_DATA;
                end
              endcase
            end
          end
        end
        ST_RDBYTE: begin
          if (phase == 2'd0) begin
            scl_next   = 1'b1;
            phase_next = 2'd1;
          end else begin
            shift_byte_next = {shift_byte[6:0], cmd.sda_in};
            scl_next        = 1'b0;
            phase_next      = 2'd0;
            if (last_bit) begin
              bit_idx_next = 3'd0;
              state_next   = ST_RDACK;
            end else begin
              bit_idx_next = bit_idx + 3'd1;
            end
          end
        end
        ST_RDACK: begin
          if (phase == 2'd0) begin
            // NACK the last byte, ACK all others.
            sda_next   = (bytes_left <= 8'd1);
            phase_next = 2'd1;
          end else if (phase == 2'd1) begin
            scl_next   = 1'b1;
            phase_next = 2'd2;
          end else begin
            scl_next        = 1'b0;
            sda_next        = 1'b1;
            phase_next      = 2'd0;
            bit_idx_next    = 3'd0;
            shift_byte_next = 8'd0;
            bytes_left_next = bytes_dec;
            state_next      = (bytes_dec == 8'd0) ? ST_STOP_OK : ST_RDBYTE;
          end
        end
        ST_STOP_OK, ST_STOP_NACK: begin
          if (phase == 2'd0) begin
            sda_next   = 1'b0;
            scl_next   = 1'b1;
            phase_next = 2'd1;
          end else begin
            sda_next        = 1'b1;
            state_next      = ST_IDLE;
            shift_byte_next = 8'd0;
            bit_idx_next    = 3'd0;
            phase_next      = 2'd0;
          end
        end
        default: begin
          state_next      = ST_IDLE;
          shift_byte_next = 8'd0;
          bit_idx_next    = 3'd0;
          phase_next      = 2'd0;
        end
      endcase
    end
  end

  // Output logic.
  always_comb begin
    rsp              = '0;
    rsp.scl_out      = scl_next;
    rsp.sda_out      = sda_next;
    rsp.data_request = (state_next == ST_WAIT_DATA);
    rsp.busy_res     = (state_next != ST_IDLE);

    if (tick && state == ST_RDBYTE && phase != 2'd0 && last_bit) begin
      rsp.read_valid = 1'b1;
      rsp.read_byte  = shift_byte_next;
      rsp.read_last  = (bytes_left <= 8'd1);
    end

    if (state == ST_IDLE && cmd.mode == MODE_PROBE && !bus_free) begin
      rsp.done_res = 1'b1;
      rsp.status   = STATUS_BUSY;
    end else if (tick && phase != 2'd0 &&
                 (state == ST_STOP_OK || state == ST_STOP_NACK)) begin
      rsp.done_res = 1'b1;
      rsp.status   = (state == ST_STOP_NACK) ? STATUS_NACK : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= 2'd0;
      bit_idx    <= 3'd0;
      bytes_left <= 8'd0;
      shift_byte <= 8'd0;
      kind       <= 2'd0;
      dev_addr   <= 8'd0;
      reg_addr   <= 8'd0;
      scl        <= 1'b1;
      sda        <= 1'b1;
    end else if (accept) begin
      state      <= state_next;
      phase      <= phase_next;
      bit_idx    <= bit_idx_next;
      bytes_left <= bytes_left_next;
      shift_byte <= shift_byte_next;
      kind       <= kind_next;
      dev_addr   <= dev_addr_next;
      reg_addr   <= reg_addr_next;
      scl        <= scl_next;
      sda        <= sda_next;
    end
  end

endmodule

// ===== rtl/i2cm_out_reg.sv =====
// ----------------------------------------------------------------------------
// I2C master register access: response register
// Holds one finished response until the sink takes it, and lets a new one in
// during the same cycle that the held one leaves.
// ----------------------------------------------------------------------------
module i2cm_out_reg
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  rsp_item_t rsp_in,
  output logic      free,
  output logic      valid,
  input  logic      ready,
  output rsp_item_t data
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= rsp_in;
    end
  end

endmodule

// ===== rtl/i2c_master_register_access.sv =====
// ----------------------------------------------------------------------------
// I2C master register access
// Bit-banged I2C master that runs probe, register read and register write
// transactions on the bus, one delay phase per tick command.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Contents
//   command   in         valid/ready    mode, addresses, length, write byte,
//                                       sampled SDA/SCL levels
//   result    out        valid/ready    SCL/SDA drive, read byte and flags,
//                                       data request, done, status, busy
//
// Every accepted command produces exactly one response, registered and offered in the cycle after acceptance.
// The sequencer state and the bus phase are computed by combinational logic
// and registered on acceptance, so a new command is taken on every clock while the
// response register is empty or is being emptied in the same cycle.
// A stalled response holds its register, and the command side stalls with it.
// Synchronous reset returns the sequencer to idle with both lines released.
//
module i2c_master_register_access
  import i2cm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  i2cm_cmd_if.sink   command,
  i2cm_rsp_if.source result
);

  rsp_item_t step_rsp;
  logic      out_free;
  logic      accept;

  // A command transaction completes when the response register has room.
  assign command.ready = out_free;
  assign accept        = command.valid && out_free;

  // The sequencer only moves on an accepted command; ticks, command starts
  // and write bytes all come through the same channel.
  i2cm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (command.data),
    .rsp    (step_rsp)
  );

  // The response register decouples the sink from the command side.
  i2cm_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .rsp_in (step_rsp),
    .free   (out_free),
    .valid  (result.valid),
    .ready  (result.ready),
    .data   (result.data)
  );

  // A finished transaction never reports itself as still in progress.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.done_res |-> !result.data.busy_res)
    else $error("done response with busy set");

  // A received byte is only reported in the middle of a read.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.read_valid |->
      result.data.busy_res && !result.data.done_res)
    else $error("read byte outside an active read");

  // A nonzero status only ever comes with completion.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.status != STATUS_OK |-> result.data.done_res)
    else $error("status reported without done");

  // A data request means the write is still in progress.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.data_request |-> result.data.busy_res)
    else $error("data request while idle");

  // Coming out of reset the response register is empty and commands flow.
  assert property (@(posedge clk) rst |=> command.ready)
    else $error("command not ready after reset");

endmodule

// ===== sim/i2c_access_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access: scoreboard
// Tracks the sequencer the same way the block should, turns every accepted
// command into the response it must produce and checks responses in order.
// ----------------------------------------------------------------------------
package i2c_access_scoreboard_pkg;
  import i2cm_pkg::*;

  class i2c_access_scoreboard;
    // Mirror of the sequencer.
    seq_state_t seq;
    logic [1:0] step;
    logic [2:0] bit_pos;
    logic [7:0] left;
    logic [7:0] shifter;
    logic [1:0] kind;
    logic [7:0] dev_byte;
    logic [7:0] reg_byte;
    logic       scl_drv;
    logic       sda_drv;

    rsp_item_t  expected_responses[$];
    int         errors;

    function new();
      seq      = ST_IDLE;
      step     = 2'd0;
      bit_pos  = 3'd0;
      left     = 8'd0;
      shifter  = 8'd0;
      kind     = 2'd0;
      dev_byte = 8'd0;
      reg_byte = 8'd0;
      scl_drv  = 1'b1;
      sda_drv  = 1'b1;
      errors   = 0;
    endfunction

    function void load(seq_state_t target, logic [7:0] value);
      seq     = target;
      shifter = value;
      bit_pos = 3'd0;
      step    = 2'd0;
    endfunction

    // One phase of shifting out a byte; true once the eighth bit is clocked.
    function bit send_step();
      case (step)
        2'd0: begin
          sda_drv = shifter[3'd7 - bit_pos];
          step = 2'd1;
          return 1'b0;
        end
        2'd1: begin
          scl_drv = 1'b1;
          step = 2'd2;
          return 1'b0;
        end
        default: begin
          scl_drv = 1'b0;
          step = 2'd0;
          if (bit_pos == 3'd7) begin
            bit_pos = 3'd0;
            return 1'b1;
          end
          bit_pos++;
          return 1'b0;
        end
      endcase
    endfunction

    // One phase of shifting in a byte; true once the eighth bit is taken.
    function bit read_step(logic sda);
      if (step == 2'd0) begin
        scl_drv = 1'b1;
        step = 2'd1;
        return 1'b0;
      end
      shifter = {shifter[6:0], sda};
      scl_drv = 1'b0;
      step = 2'd0;
      if (bit_pos == 3'd7) begin
        bit_pos = 3'd0;
        return 1'b1;
      end
      bit_pos++;
      return 1'b0;
    endfunction

    // Acknowledge slot; true on its last phase, which releases SDA.
    function bit slot_step(logic level);
      case (step)
        2'd0: begin
          sda_drv = level;
          step = 2'd1;
          return 1'b0;
        end
        2'd1: begin
          scl_drv = 1'b1;
          step = 2'd2;
          return 1'b0;
        end
        default: begin
          scl_drv = 1'b0;
          sda_drv = 1'b1;
          step = 2'd0;
          return 1'b1;
        end
      endcase
    endfunction

    // Advances the mirror by one accepted command and queues the response.
    // Returns whether the command did anything at all.
    function bit note_command(cmd_item_t c);
      rsp_item_t r;
      bit        acted;
      r = '0;
      acted = 1'b0;
      if (seq == ST_IDLE) begin
        if (c.mode inside {MODE_PROBE, MODE_READ, MODE_WRITE}) begin
          acted = 1'b1;
          if (c.mode == MODE_PROBE && !(c.sda_in && c.scl_in)) begin
            r.done_res = 1'b1;
            r.status = STATUS_BUSY;
          end else begin
            dev_byte = c.target_address;
            reg_byte = c.register_address;
            left = c.transfer_length;
            kind = c.mode[1:0];
            load(ST_START1, 8'h00);
          end
        end
      end else if (seq == ST_WAIT_DATA) begin
        if (c.mode == MODE_DATA) begin
          acted = 1'b1;
          load(ST_WRBYTE, c.write_byte);
        end
      end else if (c.mode == MODE_TICK) begin
        acted = 1'b1;
        case (seq)
          ST_START1, ST_START2: begin
            if (step == 2'd0) begin
              sda_drv = 1'b1;
              scl_drv = 1'b1;
              step = 2'd1;
            end else if (step == 2'd1) begin
              sda_drv = 1'b0;
              step = 2'd2;
            end else begin
              scl_drv = 1'b0;
              if (seq == ST_START1) load(ST_ADDRW, dev_byte);
              else load(ST_ADDRR, dev_byte | RW_READ);
            end
          end
          ST_ADDRW:  if (send_step()) load(ST_ACK_ADDRW, 8'h00);
          ST_REG:    if (send_step()) load(ST_ACK_REG, 8'h00);
          ST_ADDRR:  if (send_step()) load(ST_ACK_ADDRR, 8'h00);
          ST_WRBYTE: if (send_step()) load(ST_ACK_WR, 8'h00);
          ST_ACK_ADDRW, ST_ACK_REG, ST_ACK_ADDRR, ST_ACK_WR: begin
            if (slot_step(1'b1)) begin
              if (c.sda_in) begin
                load(ST_STOP_NACK, 8'h00);
              end else begin
                case (seq)
                  ST_ACK_ADDRW: begin
                    if (kind == KIND_PROBE) load(ST_STOP_OK, reg_byte);
                    else load(ST_REG, reg_byte);
                  end
                  ST_ACK_REG: begin
                    if (kind == KIND_READ) load(ST_START2, 8'h00);
                    else if (left == 8'd0) load(ST_STOP_OK, 8'h00);
                    else load(ST_WAIT_DATA, 8'h00);
                  end
                  ST_ACK_ADDRR: begin
                    if (left == 8'd0) load(ST_STOP_OK, 8'h00);
                    else load(ST_RDBYTE, 8'h00);
                  end
                  default: begin
                    if (left > 8'd0) left--;
                    if (left == 8'd0) load(ST_STOP_OK, 8'h00);
                    else load(ST_WAIT_DATA, 8'h00);
                  end
                endcase
              end
            end
          end
          ST_RDBYTE: begin
            if (read_step(c.sda_in)) begin
              r.read_valid = 1'b1;
              r.read_byte = shifter;
              r.read_last = (left <= 8'd1);
              load(ST_RDACK, shifter);
            end
          end
          ST_RDACK: begin
            // The master NACKs the final byte and ACKs the others.
            if (slot_step(left <= 8'd1)) begin
              if (left > 8'd0) left--;
              if (left == 8'd0) load(ST_STOP_OK, 8'h00);
              else load(ST_RDBYTE, 8'h00);
            end
          end
          ST_STOP_OK, ST_STOP_NACK: begin
            if (step == 2'd0) begin
              sda_drv = 1'b0;
              scl_drv = 1'b1;
              step = 2'd1;
            end else begin
              sda_drv = 1'b1;
              r.done_res = 1'b1;
              r.status = (seq == ST_STOP_NACK) ? STATUS_NACK : STATUS_OK;
              load(ST_IDLE, 8'h00);
            end
          end
          default: load(ST_IDLE, 8'h00);
        endcase
      end
      r.scl_out = scl_drv;
      r.sda_out = sda_drv;
      r.data_request = (seq == ST_WAIT_DATA);
      r.busy_res = (seq != ST_IDLE);
      expected_responses.push_back(r);
      return acted;
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_response(rsp_item_t got);
      rsp_item_t want;
      if (expected_responses.size() == 0) begin
        $error("response arrived with no command outstanding");
        errors++;
        return;
      end
      want = expected_responses.pop_front();
      compare_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
      compare_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
      compare_field("read_byte", want.read_byte, got.read_byte);
      compare_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
      compare_field("read_last", 8'(want.read_last), 8'(got.read_last));
      compare_field("data_request", 8'(want.data_request), 8'(got.data_request));
      compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
    endfunction
  endclass

endpackage

// ===== sim/i2c_master_register_access_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access: block-level test
// Runs directed and random probe, register read and register write sequences
// through the command channel, with random stalls on both channels, and
// checks every response field against a scoreboard that mirrors the sequencer.
// ----------------------------------------------------------------------------
module i2c_master_register_access_test;
  import i2cm_pkg::*;
  import i2c_access_scoreboard_pkg::*;

  // Undefined mode codes, which the block must ignore.
  localparam logic [2:0] MODE_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNDEF_LAST  = 3'd7;

  localparam int TOTAL_ITEMS    = 850;  // commands accepted over the whole run
  localparam int QUIET_ITEMS    = 150;  // trailing commands sent with no stalls
  localparam int HOLD_START     = 600;  // pacing count at which the long response stall begins
  localparam int HOLD_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 4000; // cycles without any transaction
  localparam int DRAIN_CYCLES   = 4;

  // How the simulated target answers acknowledge slots.
  typedef enum {ACK_ALL, NACK_ADDR, NACK_REG, NACK_LATE, ACK_SOME} ack_plan_t;
  // How read data bits and written bytes are filled.
  typedef enum {FILL_ZERO, FILL_ONE, FILL_ANY} fill_plan_t;

  typedef struct {
    cmd_item_t  cmd;
    ack_plan_t  acks;
    fill_plan_t fill;
  } txn_plan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  i2cm_cmd_if cmd_bus ();
  i2cm_rsp_if rsp_bus ();

  i2c_master_register_access dut (
    .clk     (clk),
    .rst     (rst),
    .command (cmd_bus),
    .result  (rsp_bus)
  );

  always #5 clk = ~clk;

  i2c_access_scoreboard sb = new();

  txn_plan_t  script[$];
  ack_plan_t  acks_now = ACK_ALL;
  fill_plan_t fill_now = FILL_ANY;
  bit         quiet_tail = 1'b0;
  int         idle_cycles = 0;

  // Queues one transaction (or one stray command) for the directed part.
  function automatic void add_plan(logic [2:0] mode, logic [7:0] dev, logic [7:0] regaddr,
                                   logic [7:0] len, ack_plan_t acks, fill_plan_t fill,
                                   logic sda, logic scl);
    txn_plan_t p;
    p.cmd = '0;
    p.cmd.mode = mode;
    p.cmd.target_address = dev;
    p.cmd.register_address = regaddr;
    p.cmd.transfer_length = len;
    p.cmd.write_byte = 8'($urandom);
    p.cmd.sda_in = sda;
    p.cmd.scl_in = scl;
    p.acks = acks;
    p.fill = fill;
    script.push_back(p);
  endfunction

  // Picks what to do when the sequencer is idle and the directed part is over.
  // Most picks are full transactions with short lengths; a share use any
  // length and get cut short by a NACK, so long transfers stay cheap.
  function automatic txn_plan_t random_plan();
    txn_plan_t  p;
    logic [1:0] levels;
    int         pick;
    p.cmd = '0;
    p.cmd.target_address = 8'($urandom);
    p.cmd.register_address = 8'($urandom);
    p.cmd.write_byte = 8'($urandom);
    p.cmd.sda_in = 1'b1;
    p.cmd.scl_in = 1'b1;
    p.acks = ACK_SOME;
    p.fill = FILL_ANY;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // Stray command while idle: nothing should happen.
      case ($urandom_range(0, 2))
        0: p.cmd.mode = MODE_TICK;
        1: p.cmd.mode = MODE_DATA;
        default: p.cmd.mode = 3'($urandom_range(MODE_UNDEF_FIRST, MODE_UNDEF_LAST));
      endcase
      p.cmd.sda_in = 1'($urandom);
      p.cmd.scl_in = 1'($urandom);
      p.cmd.transfer_length = 8'($urandom);
      return p;
    end
    p.cmd.mode = 3'($urandom_range(MODE_PROBE, MODE_WRITE));
    if (p.cmd.mode == MODE_PROBE && $urandom_range(0, 9) == 0) begin
      levels = 2'($urandom_range(0, 2));
      {p.cmd.sda_in, p.cmd.scl_in} = levels;
    end
    if ($urandom_range(0, 4) == 0) begin
      p.cmd.transfer_length = 8'($urandom_range(0, 255));
      p.acks = NACK_LATE;
    end else begin
      p.cmd.transfer_length = 8'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: p.acks = NACK_ADDR;
        1: p.acks = NACK_REG;
        2: p.acks = ACK_ALL;
        default: p.acks = ACK_SOME;
      endcase
    end
    return p;
  endfunction

  function automatic logic fill_bit();
    case (fill_now)
      FILL_ZERO: return 1'b0;
      FILL_ONE:  return 1'b1;
      default:   return 1'($urandom);
    endcase
  endfunction

  // Chooses the next command from where the scoreboard says the sequencer
  // stands: a new transaction when idle, a data byte when one is requested,
  // otherwise ticks, with a few stray commands mixed in.
  function automatic cmd_item_t next_command();
    cmd_item_t c;
    txn_plan_t p;
    bit        nack;
    c = '0;
    c.target_address = 8'($urandom);
    c.register_address = 8'($urandom);
    c.transfer_length = 8'($urandom);
    c.write_byte = 8'($urandom);
    c.sda_in = 1'($urandom);
    c.scl_in = 1'($urandom);
    c.mode = MODE_TICK;
    if (sb.seq == ST_IDLE) begin
      if (script.size() != 0) p = script.pop_front();
      else p = random_plan();
      acks_now = p.acks;
      fill_now = p.fill;
      return p.cmd;
    end
    if (sb.seq == ST_WAIT_DATA) begin
      case ($urandom_range(0, 9))
        0, 1: c.mode = MODE_TICK;
        2:    c.mode = 3'($urandom_range(MODE_PROBE, MODE_UNDEF_LAST));
        default: begin
          c.mode = MODE_DATA;
          if (fill_now != FILL_ANY) c.write_byte = {8{fill_bit()}};
        end
      endcase
      return c;
    end
    // Commands other than a tick are ignored while a transaction runs.
    if ($urandom_range(0, 19) == 0) begin
      c.mode = 3'($urandom_range(MODE_PROBE, MODE_UNDEF_LAST));
      return c;
    end
    if (sb.seq inside {ST_ACK_ADDRW, ST_ACK_REG, ST_ACK_ADDRR, ST_ACK_WR} &&
        sb.step == 2'd2) begin
      // This tick samples the acknowledge bit.
      case (acks_now)
        ACK_ALL:   nack = 1'b0;
        NACK_ADDR: nack = (sb.seq == ST_ACK_ADDRW);
        NACK_REG:  nack = (sb.seq == ST_ACK_REG);
        NACK_LATE: nack = (sb.seq inside {ST_ACK_ADDRR, ST_ACK_WR});
        default:   nack = ($urandom_range(0, 19) == 0);
      endcase
      c.sda_in = nack;
    end else if (sb.seq == ST_RDBYTE) begin
      c.sda_in = fill_bit();
    end
    return c;
  endfunction

  // Offers commands until the whole run has had its share accepted. The next
  // command is chosen right after the previous one is accepted, so it always
  // sees the sequencer state it will act on.
  task automatic run_commands();
    int counted;
    int gap;
    counted = 0;
    cmd_bus.valid <= 1'b1;
    cmd_bus.data <= next_command();
    forever begin
      @(posedge clk);
      if (cmd_bus.valid && cmd_bus.ready) begin
        void'(sb.note_command(cmd_bus.data));
        counted++;
        if (counted >= TOTAL_ITEMS) begin
          cmd_bus.valid <= 1'b0;
          break;
        end
        quiet_tail = (counted >= TOTAL_ITEMS - QUIET_ITEMS);
        if (!quiet_tail && $urandom_range(0, 11) == 0) begin
          gap = $urandom_range(1, 19);
          cmd_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.data <= next_command();
      end
    end
  endtask

  // Reset is held at the start and never asserted again.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Response side pacing. Besides the short random stalls there is one long
  // hold-off; the command side keeps offering during it, so the response
  // register fills and the block has to stall its command input.
  initial begin : pace_responses
    int  cycles;
    int  span;
    bit  long_hold_done;
    cycles = 0;
    long_hold_done = 1'b0;
    rsp_bus.ready <= 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      cycles++;
      if (!long_hold_done && cycles >= HOLD_START) begin
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        cycles += HOLD_CYCLES;
        long_hold_done = 1'b1;
        rsp_bus.ready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
        span = $urandom_range(1, 19);
        rsp_bus.ready <= 1'b0;
        repeat (span) @(posedge clk);
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Every accepted response is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) sb.check_response(rsp_bus.data);
  end

  // Watchdog: the run is stuck if neither channel moves for too long.
  always @(posedge clk) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    cmd_bus.valid <= 1'b0;
    cmd_bus.data <= '0;

    // Directed part. Stray commands while idle come first: a tick, a data
    // byte nobody asked for and the undefined modes.
    add_plan(MODE_TICK, 8'h00, 8'h00, 8'h00, ACK_ALL, FILL_ANY, 1'b1, 1'b1);
    add_plan(MODE_DATA, 8'hFF, 8'hFF, 8'hFF, ACK_ALL, FILL_ANY, 1'b0, 1'b0);
    add_plan(MODE_UNDEF_FIRST, 8'h12, 8'h34, 8'h02, ACK_ALL, FILL_ANY, 1'b1, 1'b1);
    add_plan(MODE_UNDEF_FIRST + 3'd1, 8'h12, 8'h34, 8'h02, ACK_ALL, FILL_ANY, 1'b1, 1'b1);
    add_plan(MODE_UNDEF_LAST, 8'h12, 8'h34, 8'h02, ACK_ALL, FILL_ANY, 1'b1, 1'b1);
    // A probe must report a busy bus when either line is seen low.
    add_plan(MODE_PROBE, 8'hA0, 8'h00, 8'h00, ACK_ALL, FILL_ANY, 1'b0, 1'b1);
    add_plan(MODE_PROBE, 8'hA0, 8'h00, 8'h00, ACK_ALL, FILL_ANY, 1'b1, 1'b0);
    // Probes answered with an ACK and with a NACK.
    add_plan(MODE_PROBE, 8'h00, 8'h00, 8'h00, ACK_ALL, FILL_ANY, 1'b1, 1'b1);
    add_plan(MODE_PROBE, 8'hFF, 8'hFF, 8'hFF, NACK_ADDR, FILL_ANY, 1'b1, 1'b1);
    // Reads: zero length stops after the read address, then all-ones data.
    add_plan(MODE_READ, 8'hA0, 8'h00, 8'h00, ACK_ALL, FILL_ANY, 1'b1, 1'b1);
    add_plan(MODE_READ, 8'hFF, 8'hFF, 8'h02, ACK_ALL, FILL_ONE, 1'b1, 1'b1);
    // Writes: zero length, then a byte of zeros.
    add_plan(MODE_WRITE, 8'h55, 8'hAA, 8'h00, ACK_ALL, FILL_ANY, 1'b1, 1'b1);
    add_plan(MODE_WRITE, 8'hA2, 8'h10, 8'h01, ACK_ALL, FILL_ZERO, 1'b1, 1'b1);
    // Maximum lengths, cut short by a NACK on the first data byte or on
    // the address with the read flag; then a NACK on the register byte.
    add_plan(MODE_WRITE, 8'h3C, 8'h81, 8'hFF, NACK_LATE, FILL_ANY, 1'b1, 1'b1);
    add_plan(MODE_READ, 8'h3C, 8'h81, 8'hFF, NACK_LATE, FILL_ANY, 1'b1, 1'b1);
    add_plan(MODE_WRITE, 8'h7E, 8'h01, 8'h03, NACK_REG, FILL_ANY, 1'b1, 1'b1);

    wait (!rst);
    @(posedge clk);
    run_commands();

    // Let every outstanding response arrive and the bench drain before deciding.
    while (sb.expected_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
